>>> hdl/hpss_median_separator_defines.svh
// Assertion macros shared by the median separator RTL.
// Needs clk_i and rst_ni in the scope of every use.
`ifndef HPSS_MEDIAN_SEPARATOR_DEFINES_SVH
`define HPSS_MEDIAN_SEPARATOR_DEFINES_SVH

// Checks that prop holds at every clock edge outside reset.
`define HPSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that cond implies prop in the following cycle.
`define HPSS_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

>>> hdl/hpss_pkg.sv
// Package for the median separator: field widths, codes and control structs.
// Used by every RTL file of the block.
`default_nettype none
package hpss_pkg;

  localparam int BIN_W    = 10;
  localparam int ROW_W    = 6;
  localparam int MODE_W   = 2;
  localparam int MAG_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 11;
  localparam int CNT_W    = 8;

  localparam int DEF_MAX_WINDOW   = 64;
  localparam int DEF_MAX_BINS     = 1024;
  localparam int DEF_HISTORY_ROWS = 64;
  localparam int MIN_HIST_ROWS    = 3;

  localparam logic [MODE_W-1:0] MODE_HIST  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FRAME = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_VALID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT    = 2'd2;

  localparam logic [1:0] SRC_HIST = 2'd0;
  localparam logic [1:0] SRC_BIN  = 2'd1;
  localparam logic [1:0] SRC_NBR  = 2'd2;

  typedef struct packed {
    logic             take;
    logic             clear;
    logic             rd_en;
    logic [1:0]       src;
    logic [CNT_W-1:0] idx;
    logic             shift;
    logic             odd;
    logic             latch_harm;
    logic             latch_perc;
    logic             load_out;
  } hpss_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] rows;
    logic             h_hist;
    logic [CNT_W-1:0] win;
    logic             out_free;
  } hpss_sts_t;

endpackage
`default_nettype wire

>>> hdl/hpss_req_if.sv
// Request channel of the median separator: valid, ready and the request fields.
// Depends on hpss_pkg for the field widths.
`default_nettype none
interface hpss_req_if
  import hpss_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [ROW_W-1:0]  row;
  logic [BIN_W-1:0]  bin;
  logic [MAG_W-1:0]  sample_value;

  modport source (output valid, mode, row, bin, sample_value, input ready);
  modport sink (input valid, mode, row, bin, sample_value, output ready);
endinterface
`default_nettype wire

>>> hdl/hpss_rsp_if.sv
// Result channel of the median separator: valid, ready and the result fields.
// Depends on hpss_pkg for the field widths.
`default_nettype none
interface hpss_rsp_if
  import hpss_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [BIN_W-1:0] result_bin;
  logic [MAG_W-1:0] harmonic;
  logic [MAG_W-1:0] percussive;

  modport source (output valid, result_bin, harmonic, percussive, input ready);
  modport sink (input valid, result_bin, harmonic, percussive, output ready);
endinterface
`default_nettype wire

>>> hdl/hpss_ctrl.sv
// Controller of the median separator: sequences gather, select and output steps.
// Depends on hpss_pkg and the assertion macros header.
`default_nettype none
`include "hpss_median_separator_defines.svh"
module hpss_ctrl
  import hpss_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  input  wire logic [MODE_W-1:0] req_mode_i,
  output logic                   req_ready_o,
  input  wire hpss_sts_t         sts_i,
  output hpss_cmd_t              cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_GATH  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_SEL   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]       state_q, state_d;
  logic             phase_q, phase_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] sel_q, sel_d;
  logic [1:0]       src_q, src_d;

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    k_d     = k_q;
    cnt_d   = cnt_q;
    sel_d   = sel_q;
    src_d   = src_q;
    cmd_o   = '0;
    cmd_o.idx = k_q;
    cmd_o.src = src_q;
    cmd_o.odd = cnt_q[0];
    req_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.take  = req_valid_i;
        if (req_valid_i && req_mode_i == MODE_QUERY) begin
          cmd_o.clear = 1'b1;
          phase_d = 1'b0;
          k_d     = '0;
          cnt_d   = sts_i.h_hist ? sts_i.rows : CNT_W'(1);
          src_d   = sts_i.h_hist ? SRC_HIST : SRC_BIN;
          state_d = ST_GATH;
        end
      end
      ST_GATH: begin
        cmd_o.rd_en = 1'b1;
        k_d = k_q + 1'b1;
        if (k_q == cnt_q - 1'b1) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        sel_d   = cnt_q[0] ? (cnt_q >> 1) : ((cnt_q >> 1) - 1'b1);
        state_d = ST_SEL;
      end
      ST_SEL: begin
        if (sel_q == '0) begin
          if (!phase_q) begin
            cmd_o.latch_harm = 1'b1;
            cmd_o.clear = 1'b1;
            phase_d = 1'b1;
            k_d     = '0;
            cnt_d   = sts_i.win;
            src_d   = SRC_NBR;
            state_d = ST_GATH;
          end else begin
            cmd_o.latch_perc = 1'b1;
            state_d = ST_OUT;
          end
        end else begin
          cmd_o.shift = 1'b1;
          sel_d = sel_q - 1'b1;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= 1'b0;
      k_q     <= '0;
      cnt_q   <= '0;
      sel_q   <= '0;
      src_q   <= SRC_HIST;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      k_q     <= k_d;
      cnt_q   <= cnt_d;
      sel_q   <= sel_d;
      src_q   <= src_d;
    end
  end

  `HPSS_ASSERT(a_gather_bound, state_q != ST_GATH || k_q < cnt_q, "gather index overran count")
  `HPSS_ASSERT_NEXT(a_drain_to_sel, state_q == ST_DRAIN, state_q == ST_SEL, "drain not followed by select")
  `HPSS_ASSERT_NEXT(a_harm_to_perc, state_q == ST_SEL && sel_q == '0 && !phase_q,
    state_q == ST_GATH && phase_q && src_q == SRC_NBR, "percussive pass did not follow")

endmodule
`default_nettype wire

>>> hdl/hpss_dpath.sv
// Datapath of the median separator: stores, configuration, sorting cells, result.
// Depends on hpss_pkg; driven by hpss_ctrl through hpss_cmd_t.
`default_nettype none
module hpss_dpath
  import hpss_pkg::*;
#(
  parameter int MAX_WINDOW   = DEF_MAX_WINDOW,
  parameter int MAX_BINS     = DEF_MAX_BINS,
  parameter int HISTORY_ROWS = DEF_HISTORY_ROWS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_data_i,
  input  wire logic [MODE_W-1:0]    mode_i,
  input  wire logic [ROW_W-1:0]     row_i,
  input  wire logic [BIN_W-1:0]     bin_i,
  input  wire logic [MAG_W-1:0]     sample_value_i,
  input  wire hpss_cmd_t            cmd_i,
  output hpss_sts_t                 sts_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [BIN_W-1:0]          out_bin_o,
  output logic [MAG_W-1:0]          out_harm_o,
  output logic [MAG_W-1:0]          out_perc_o
);

  localparam int HDEPTH  = HISTORY_ROWS * MAX_BINS;
  localparam int HAW     = $clog2(HDEPTH);
  localparam int FAW     = $clog2(MAX_BINS);
  localparam int NW      = $clog2(MAX_BINS + 1);
  localparam int SW      = ((NW > BIN_W) ? NW : BIN_W) + 2;
  localparam int ROW_LIM = (MAX_WINDOW < HISTORY_ROWS) ? MAX_WINDOW : HISTORY_ROWS;

  logic [6:0]          frames_q;
  logic [6:0]          win_q;
  logic [10:0]         bins_q;
  logic [CNT_W-1:0]    rows_eff, win_eff;
  logic [NW-1:0]       n_eff;
  logic [BIN_W-1:0]    bin_q;
  logic [MAG_W-1:0]    hist_mem [HDEPTH];
  logic [MAG_W-1:0]    frame_mem [MAX_BINS];
  logic [MAG_W-1:0]    hist_rd_q, frame_rd_q;
  logic                pend_q, src_hist_q, oor_q;
  logic [HAW-1:0]      hist_wa, hist_ra;
  logic [FAW-1:0]      frame_ra;
  logic signed [SW-1:0] pos;
  logic [MAG_W-1:0]    key;
  logic [MAG_W-1:0]    cell_q [MAX_WINDOW];
  logic                vld_q [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] gt;
  logic [MAG_W:0]      mid_sum;
  logic [MAG_W-1:0]    med;
  logic [MAG_W-1:0]    harm_q, perc_q;
  logic                out_vld_q;
  logic [BIN_W-1:0]    out_bin_q;
  logic [MAG_W-1:0]    out_harm_q, out_perc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= '0;
      win_q    <= 7'd1;
      bins_q   <= 11'd1024;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAMES_VALID: frames_q <= cfg_data_i[6:0];
        CFG_WINDOW_WIDTH: win_q <= cfg_data_i[6:0];
        CFG_BIN_COUNT:    bins_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    rows_eff = (int'(frames_q) > ROW_LIM) ? CNT_W'(ROW_LIM) : CNT_W'(frames_q);
    if (win_q == '0) begin
      win_eff = CNT_W'(1);
    end else if (int'(win_q) > MAX_WINDOW) begin
      win_eff = CNT_W'(MAX_WINDOW);
    end else begin
      win_eff = CNT_W'(win_q);
    end
    if (int'(bins_q) > MAX_BINS) begin
      n_eff = NW'(MAX_BINS);
    end else if (bins_q == '0) begin
      n_eff = NW'(1);
    end else begin
      n_eff = NW'(bins_q);
    end
  end

  assign sts_o.rows     = rows_eff;
  assign sts_o.h_hist   = int'(rows_eff) >= MIN_HIST_ROWS;
  assign sts_o.win      = win_eff;
  assign sts_o.out_free = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && mode_i == MODE_QUERY) begin
      bin_q <= bin_i;
    end
  end

  assign hist_wa = HAW'(int'(row_i) * MAX_BINS + int'(bin_i));
  assign hist_ra = HAW'(int'(cmd_i.idx) * MAX_BINS + int'(bin_q));

  always_comb begin
    pos = $signed(SW'(bin_q)) + $signed(SW'(cmd_i.idx)) - $signed(SW'(win_eff >> 1));
    if (cmd_i.src == SRC_NBR) begin
      if (pos < 0) begin
        frame_ra = '0;
      end else if (pos >= $signed(SW'(n_eff))) begin
        frame_ra = FAW'(n_eff - 1'b1);
      end else begin
        frame_ra = FAW'(pos);
      end
    end else begin
      frame_ra = FAW'(bin_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && mode_i == MODE_HIST && int'(row_i) < HISTORY_ROWS
        && int'(bin_i) < MAX_BINS) begin
      hist_mem[hist_wa] <= sample_value_i;
    end
    hist_rd_q <= hist_mem[hist_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && mode_i == MODE_FRAME && int'(bin_i) < MAX_BINS) begin
      frame_mem[FAW'(bin_i)] <= sample_value_i;
    end
    frame_rd_q <= frame_mem[frame_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= 1'b0;
      src_hist_q <= 1'b0;
      oor_q      <= 1'b0;
    end else begin
      pend_q     <= cmd_i.rd_en;
      src_hist_q <= cmd_i.src == SRC_HIST;
      oor_q      <= cmd_i.src == SRC_BIN && int'(bin_q) >= MAX_BINS;
    end
  end

  assign key = src_hist_q ? hist_rd_q : (oor_q ? '0 : frame_rd_q);

  // Cells hold the values gathered so far in ascending order; empty cells act
  // as larger than any value, so an insert shifts the upper part up by one.
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    assign gt[i] = !vld_q[i] || cell_q[i] > key;

    always_ff @(posedge clk_i) begin
      if (pend_q) begin
        if (gt[i]) begin
          if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
            cell_q[i] <= cell_q[(i > 0) ? i - 1 : 0];
          end else begin
            cell_q[i] <= key;
          end
        end
      end else if (cmd_i.shift && i < MAX_WINDOW - 1) begin
        cell_q[i] <= cell_q[(i < MAX_WINDOW - 1) ? i + 1 : i];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (cmd_i.clear) begin
        vld_q[i] <= 1'b0;
      end else if (pend_q) begin
        vld_q[i] <= (i == 0) ? 1'b1 : vld_q[(i > 0) ? i - 1 : 0];
      end
    end
  end

  assign mid_sum = {1'b0, cell_q[0]} + {1'b0, cell_q[1]};
  assign med     = cmd_i.odd ? cell_q[0] : mid_sum[MAG_W:1];

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_harm) begin
      harm_q <= med;
    end
    if (cmd_i.latch_perc) begin
      perc_q <= med;
    end
    if (cmd_i.load_out) begin
      out_bin_q  <= bin_q;
      out_harm_q <= harm_q;
      out_perc_q <= perc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_bin_o   = out_bin_q;
  assign out_harm_o  = out_harm_q;
  assign out_perc_o  = out_perc_q;

endmodule
`default_nettype wire

>>> hdl/hpss_median_separator.sv
// A query gathers rows harmonic entries (one when fewer than three rows are valid),
// then win window entries, and selects each median by shifting out about half of
// each count. Both gathers read one store entry per cycle, each over the single
// read port of its store. Reset clears configuration, control, the cell valid
// flags and the result valid; stores are undefined.
`default_nettype none
module hpss_median_separator
  import hpss_pkg::*;
#(
  parameter int MAX_WINDOW   = DEF_MAX_WINDOW,
  parameter int MAX_BINS     = DEF_MAX_BINS,
  parameter int HISTORY_ROWS = DEF_HISTORY_ROWS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_data_i,
  hpss_req_if.sink                  req,
  hpss_rsp_if.source                rsp
);

  hpss_cmd_t cmd;
  hpss_sts_t sts;

  hpss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_mode_i  (req.mode),
    .req_ready_o (req.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hpss_dpath #(
    .MAX_WINDOW   (MAX_WINDOW),
    .MAX_BINS     (MAX_BINS),
    .HISTORY_ROWS (HISTORY_ROWS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .mode_i         (req.mode),
    .row_i          (req.row),
    .bin_i          (req.bin),
    .sample_value_i (req.sample_value),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (rsp.valid),
    .out_ready_i    (rsp.ready),
    .out_bin_o      (rsp.result_bin),
    .out_harm_o     (rsp.harmonic),
    .out_perc_o     (rsp.percussive)
  );

endmodule
`default_nettype wire

>>> dv/hpss_median_separator_tb.sv
// Self-checking testbench for hpss_median_separator: directed and random requests
// checked against an in-bench median predictor. Needs hpss_pkg and both channel interfaces.
`timescale 1ns / 1ps
module hpss_median_separator_tb;
  import hpss_pkg::*;

  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 250;

  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic [MAG_W-1:0] harm;
    logic [MAG_W-1:0] perc;
  } sep_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;

  hpss_req_if req_ch ();
  hpss_rsp_if rsp_ch ();

  hpss_median_separator dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic [MAG_W-1:0] hist_mag [64][1024];
  bit hist_set [64][1024];
  logic [MAG_W-1:0] frame_mag [1024];
  bit frame_set [1024];
  int hist_rows = 0;
  int nbr_width = 1;
  int bin_limit = 1024;
  sep_result_t pending_q [$];
  int errors = 0;
  int snd_idle = 0;
  int rcv_idle = 0;
  int sent = 0;
  int stall_cnt = 0;
  int bin_pool [6];

  initial begin
    req_ch.valid = 1'b0;
    req_ch.mode = '0;
    req_ch.row = '0;
    req_ch.bin = '0;
    req_ch.sample_value = '0;
    rsp_ch.ready = 1'b0;
  end

  function automatic logic [MAG_W-1:0] mid_value(logic [MAG_W-1:0] v[64], int cnt);
    logic [MAG_W-1:0] key;
    logic [MAG_W:0] sum;
    int j;
    for (int i = 1; i < cnt; i++) begin
      key = v[i];
      j = i;
      while (j > 0 && v[j-1] > key) begin
        v[j] = v[j-1];
        j--;
      end
      v[j] = key;
    end
    if (cnt % 2 == 1) return v[cnt/2];
    sum = {1'b0, v[cnt/2-1]} + {1'b0, v[cnt/2]};
    return sum[MAG_W:1];
  endfunction

  function automatic int nbr_index(int b, int w);
    int idx;
    idx = b + w - nbr_width / 2;
    if (idx < 0) idx = 0;
    else if (idx >= bin_limit) idx = bin_limit - 1;
    return idx;
  endfunction

  function automatic sep_result_t separate(int b);
    logic [MAG_W-1:0] buf_v [64];
    sep_result_t r;
    r.bin = b[BIN_W-1:0];
    if (hist_rows >= MIN_HIST_ROWS) begin
      for (int t = 0; t < hist_rows; t++) buf_v[t] = hist_mag[t][b];
      r.harm = mid_value(buf_v, hist_rows);
    end else begin
      r.harm = frame_mag[b];
    end
    for (int w = 0; w < nbr_width; w++) buf_v[w] = frame_mag[nbr_index(b, w)];
    r.perc = mid_value(buf_v, nbr_width);
    return r;
  endfunction

  function automatic logic [MAG_W-1:0] rand_mag();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 32'hFFFF_FFFE - $urandom_range(0, 3);
      default: return $urandom();
    endcase
  endfunction

  task automatic settle();
    req_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, int value);
    settle();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value[CFG_DAT_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_FRAMES_VALID: hist_rows = (value & 'h7F) > 64 ? 64 : (value & 'h7F);
      CFG_WINDOW_WIDTH: begin
        nbr_width = (value & 'h7F) > 64 ? 64 : (value & 'h7F);
        if (nbr_width == 0) nbr_width = 1;
      end
      CFG_BIN_COUNT: begin
        bin_limit = (value & 'h7FF) > 1024 ? 1024 : (value & 'h7FF);
        if (bin_limit == 0) bin_limit = 1;
      end
      default: ;
    endcase
  endtask

  task automatic send(logic [MODE_W-1:0] mode, int row, int b, logic [MAG_W-1:0] val);
    if ($urandom_range(0, 99) < snd_idle) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < snd_idle);
    end
    req_ch.valid <= 1'b1;
    req_ch.mode <= mode;
    req_ch.row <= row[ROW_W-1:0];
    req_ch.bin <= b[BIN_W-1:0];
    req_ch.sample_value <= val;
    do @(posedge clk_i); while (!req_ch.ready);
    sent++;
    case (mode)
      MODE_HIST: begin
        hist_mag[row][b] = val;
        hist_set[row][b] = 1'b1;
      end
      MODE_FRAME: begin
        frame_mag[b] = val;
        frame_set[b] = 1'b1;
      end
      MODE_QUERY: pending_q.push_back(separate(b));
      default: ;
    endcase
  endtask

  // Writes every entry a query of this bin reads that has not been written yet.
  task automatic fill_for(int b);
    if (hist_rows >= MIN_HIST_ROWS) begin
      for (int t = 0; t < hist_rows; t++)
        if (!hist_set[t][b]) send(MODE_HIST, t, b, rand_mag());
    end else if (!frame_set[b]) begin
      send(MODE_FRAME, $urandom_range(0, 63), b, rand_mag());
    end
    for (int w = 0; w < nbr_width; w++)
      if (!frame_set[nbr_index(b, w)])
        send(MODE_FRAME, $urandom_range(0, 63), nbr_index(b, w), rand_mag());
  endtask

  task automatic query(int b);
    fill_for(b);
    send(MODE_QUERY, $urandom_range(0, 63), b, $urandom());
  endtask

  task automatic test_defaults();
    write_cfg(CFG_FRAMES_VALID, 0);
    write_cfg(CFG_WINDOW_WIDTH, 1);
    write_cfg(CFG_BIN_COUNT, 1024);
    send(MODE_FRAME, 0, 0, '0);
    send(MODE_FRAME, 63, 1023, '1);
    send(MODE_HIST, 63, 1023, '1);
    send(MODE_HIST, 0, 0, '0);
    send(MODE_NONE, 21, 682, 32'hAAAA_5555);
    query(0);
    query(1023);
    send(MODE_NONE, 42, 341, 32'h5555_AAAA);
    query(1023);
    settle();
  endtask

  task automatic test_large_settings();
    write_cfg(CFG_FRAMES_VALID, 127);
    write_cfg(CFG_WINDOW_WIDTH, 127);
    write_cfg(CFG_BIN_COUNT, 2047);
    query(1023);
    settle();
    write_cfg(CFG_FRAMES_VALID, 64);
    write_cfg(CFG_WINDOW_WIDTH, 64);
    write_cfg(CFG_BIN_COUNT, 1024);
    query(0);
    settle();
  endtask

  task automatic test_edge_cases();
    write_cfg(CFG_FRAMES_VALID, 2);
    write_cfg(CFG_WINDOW_WIDTH, 0);
    write_cfg(CFG_BIN_COUNT, 0);
    query(5);
    settle();
    write_cfg(CFG_FRAMES_VALID, 4);
    write_cfg(CFG_WINDOW_WIDTH, 4);
    write_cfg(CFG_BIN_COUNT, 8);
    query(3);
    query(700);
    write_cfg(CFG_FRAMES_VALID, 3);
    write_cfg(CFG_WINDOW_WIDTH, 3);
    query(7);
    settle();
  endtask

  task automatic random_config();
    int bc;
    write_cfg(CFG_FRAMES_VALID, $urandom_range(0, 9));
    write_cfg(CFG_WINDOW_WIDTH, $urandom_range(0, 9));
    case ($urandom_range(0, 5))
      0: bc = 0;
      1: bc = 1;
      2: bc = 2047;
      3: bc = 1024;
      default: bc = $urandom_range(2, 1024);
    endcase
    write_cfg(CFG_BIN_COUNT, bc);
    foreach (bin_pool[i]) begin
      case ($urandom_range(0, 5))
        0: bin_pool[i] = 0;
        1: bin_pool[i] = 1023;
        2: bin_pool[i] = bin_limit - 1 + $urandom_range(0, 1);
        default: bin_pool[i] = $urandom_range(0, 1023);
      endcase
      if (bin_pool[i] > 1023) bin_pool[i] = 1023;
    end
  endtask

  task automatic test_random(int idle_snd, int idle_rcv, int budget);
    int stop_at;
    int b;
    snd_idle = idle_snd;
    rcv_idle = idle_rcv;
    repeat (2) begin
      random_config();
      stop_at = sent + budget / 2;
      while (sent < stop_at) begin
        b = bin_pool[$urandom_range(0, 5)];
        case ($urandom_range(0, 9))
          0: send($urandom_range(0, 1) ? MODE_NONE : MODE_HIST,
                  $urandom_range(0, 63), $urandom_range(0, 1023), $urandom());
          1: send(MODE_FRAME, $urandom_range(0, 63), $urandom_range(0, 1023), rand_mag());
          2, 3: send(MODE_HIST, $urandom_range(0, 9), b, rand_mag());
          4: send(MODE_FRAME, $urandom_range(0, 63),
                  nbr_index(b, $urandom_range(0, nbr_width - 1)), rand_mag());
          default: query(b);
        endcase
      end
      settle();
    end
  endtask

  always @(posedge clk_i) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= rcv_idle);
  end

  always @(posedge clk_i) begin
    sep_result_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result bin=%0d harm=%h perc=%h", $time,
                 rsp_ch.result_bin, rsp_ch.harmonic, rsp_ch.percussive);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (rsp_ch.result_bin !== want.bin) begin
          $display("%0t: result_bin expected %0d actual %0d", $time, want.bin,
                   rsp_ch.result_bin);
          errors++;
        end
        if (rsp_ch.harmonic !== want.harm) begin
          $display("%0t: harmonic expected %h actual %h", $time, want.harm,
                   rsp_ch.harmonic);
          errors++;
        end
        if (rsp_ch.percussive !== want.perc) begin
          $display("%0t: percussive expected %h actual %h", $time, want.perc,
                   rsp_ch.percussive);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || !rst_ni) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_large_settings();
    test_edge_cases();
    test_random(7, 60, 100);
    test_random(60, 7, 100);
    test_random(0, 0, 100);
    req_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> hpss_median_separator.f
+incdir+hdl
hdl/hpss_pkg.sv
hdl/hpss_req_if.sv
hdl/hpss_rsp_if.sv
hdl/hpss_ctrl.sv
hdl/hpss_dpath.sv
hdl/hpss_median_separator.sv
dv/hpss_median_separator_tb.sv
